// ----- design/mtis_pkg.sv -----
// mtis_pkg: shared types and constants for the message type interval stats unit
// holds the table size, field structs and result status codes
// no dependencies
`timescale 1ns / 1ps

package mtis_pkg;

    localparam int TYPE_SLOTS = 16;
    localparam int SLOT_W     = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TYPE_SLOTS + 1);

    localparam logic [31:0] GAP_LIMIT = 32'd60000;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_ADDED   = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [11:0] msg_type;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] hit_count;
        logic [15:0] mean_gap_ms;
        logic [15:0] worst_dev_ms;
        logic [4:0]  types_known;
    } t_out_item;

    typedef struct packed {
        logic [11:0] code;
        logic [31:0] hits;
        logic [31:0] last;
        logic [15:0] mean;
        logic [15:0] worst;
    } t_entry;

endpackage

// ----- design/message_type_interval_stats_unit.sv -----
// message_type_interval_stats_unit: per message type arrival interval statistics
// table in a single-port style memory searched one slot per cycle
// depends on mtis_pkg
//
// usage:
//   input channel i_valid / o_ready / i_data carries one frame's message type and
//   millisecond timestamp; output channel o_valid / i_ready / o_data carries one
//   result per input transfer (status, slot, hit count, mean gap, worst deviation,
//   entries in use)
//   o_ready is high only while the sequencer is idle; one item is worked on at a time
//   the table is searched in slot order, one memory read per cycle; a hit ends the
//   search at its slot and a miss ends it once every entry in use has been read
//   a hit then goes through the clamped gap step and the mean and deviation update
//   o_ready returns with the same clock edge that loads the result register
//   the result sits in an output register; a new item may be accepted while it waits,
//   and the sequencer holds at its last step until that register is free
//   reset clears the entry count and the control state only; table contents are not
//   cleared, as entries past the count are never read
`timescale 1ns / 1ps

module message_type_interval_stats_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mtis_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mtis_pkg::t_out_item  o_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_GAP,
        S_UPD
    } t_state;

    t_state                       r_state, n_state;
    logic [mtis_pkg::CNT_W-1:0]   r_used, n_used;
    logic [mtis_pkg::CNT_W-1:0]   r_issue, n_issue;
    logic                         r_rd_v, n_rd_v;
    logic [mtis_pkg::SLOT_W-1:0]  r_rd_idx, n_rd_idx;
    logic [mtis_pkg::SLOT_W-1:0]  r_slot, n_slot;
    logic [11:0]                  r_code, n_code;
    logic [31:0]                  r_now, n_now;
    logic [15:0]                  r_gap, n_gap;
    logic                         r_has_gap, n_has_gap;
    logic                         r_out_v, n_out_v;
    mtis_pkg::t_out_item          r_out, n_out;

    mtis_pkg::t_entry             r_mem [mtis_pkg::TYPE_SLOTS];
    mtis_pkg::t_entry             r_rd;

    logic                         rd_en;
    logic [mtis_pkg::SLOT_W-1:0]  rd_addr;
    logic                         wr_en;
    logic [mtis_pkg::SLOT_W-1:0]  wr_addr;
    mtis_pkg::t_entry             wr_data;

    logic                         out_free;
    logic                         hit;
    logic                         searched;
    logic [31:0]                  diff;
    logic [17:0]                  mix_sum;
    logic [15:0]                  dev;
    logic [15:0]                  new_mean;
    logic [15:0]                  new_worst;

    assign out_free = !r_out_v || i_ready;
    assign hit      = r_rd_v && (r_rd.code == r_code);
    assign searched = (r_issue >= r_used);

    assign diff     = r_now - r_rd.last;
    assign mix_sum  = {1'b0, r_rd.mean, 1'b0} + {2'b00, r_rd.mean} + {2'b00, r_gap};
    assign dev      = (r_gap > r_rd.mean) ? (r_gap - r_rd.mean) : (r_rd.mean - r_gap);

    always_comb begin
        new_mean  = r_rd.mean;
        new_worst = r_rd.worst;
        if (r_has_gap) begin
            if (r_rd.mean == 16'd0) begin
                new_mean = r_gap;
            end else begin
                new_mean = mix_sum[17:2];
                if (dev > r_rd.worst) begin
                    new_worst = dev;
                end
            end
        end
    end

    // memory port control
    always_comb begin
        rd_en   = (r_state == S_SRCH) && !hit && !searched;
        rd_addr = r_issue[mtis_pkg::SLOT_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_data = '{code: r_code, hits: r_rd.hits + 32'd1, last: r_now,
                    mean: new_mean, worst: new_worst};
        if ((r_state == S_SRCH) && !hit && searched && out_free
                && (r_used < mtis_pkg::CNT_W'(mtis_pkg::TYPE_SLOTS))) begin
            wr_en   = 1'b1;
            wr_addr = r_used[mtis_pkg::SLOT_W-1:0];
            wr_data = '{code: r_code, hits: 32'd1, last: r_now,
                        mean: 16'd0, worst: 16'd0};
        end else if ((r_state == S_UPD) && out_free) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_issue   = r_issue;
        n_rd_v    = r_rd_v;
        n_rd_idx  = r_rd_idx;
        n_slot    = r_slot;
        n_code    = r_code;
        n_now     = r_now;
        n_gap     = r_gap;
        n_has_gap = r_has_gap;
        n_out_v   = r_out_v && !i_ready;
        n_out     = r_out;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_code  = i_data.msg_type;
                    n_now   = i_data.now_ms;
                    n_issue = '0;
                    n_rd_v  = 1'b0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (hit) begin
                    n_slot  = r_rd_idx;
                    n_rd_v  = 1'b0;
                    n_state = S_GAP;
                end else if (!searched) begin
                    n_rd_v   = 1'b1;
                    n_rd_idx = rd_addr;
                    n_issue  = r_issue + 1'b1;
                end else begin
                    n_rd_v = 1'b0;
                    if (out_free) begin
                        n_out_v = 1'b1;
                        if (r_used < mtis_pkg::CNT_W'(mtis_pkg::TYPE_SLOTS)) begin
                            n_used = r_used + 1'b1;
                            n_out  = '{status: mtis_pkg::ST_ADDED,
                                       slot: 4'(r_used[mtis_pkg::SLOT_W-1:0]),
                                       hit_count: 32'd1, mean_gap_ms: 16'd0,
                                       worst_dev_ms: 16'd0,
                                       types_known: 5'(r_used + 1'b1)};
                        end else begin
                            n_out  = '{status: mtis_pkg::ST_FULL, slot: 4'd0,
                                       hit_count: 32'd0, mean_gap_ms: 16'd0,
                                       worst_dev_ms: 16'd0,
                                       types_known: 5'(r_used)};
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            S_GAP: begin
                // wrapping gap clamped to the limit
                n_has_gap = (r_rd.last != 32'd0);
                n_gap     = (diff > mtis_pkg::GAP_LIMIT) ? mtis_pkg::GAP_LIMIT[15:0]
                                                         : diff[15:0];
                n_state   = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_out_v = 1'b1;
                    n_out   = '{status: mtis_pkg::ST_UPDATED, slot: 4'(r_slot),
                                hit_count: r_rd.hits + 32'd1, mean_gap_ms: new_mean,
                                worst_dev_ms: new_worst, types_known: 5'(r_used)};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_issue <= '0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_issue <= n_issue;
            r_rd_v  <= n_rd_v;
            r_out_v <= n_out_v;
        end
        r_rd_idx  <= n_rd_idx;
        r_slot    <= n_slot;
        r_code    <= n_code;
        r_now     <= n_now;
        r_gap     <= n_gap;
        r_has_gap <= n_has_gap;
        r_out     <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // checks
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= mtis_pkg::CNT_W'(mtis_pkg::TYPE_SLOTS))
        else $error("entry count beyond table size");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_used != $past(r_used)) |-> (r_used == $past(r_used) + 1'b1))
        else $error("entry count moved by more than one");

    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("table read and write in the same cycle");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == mtis_pkg::ST_FULL)
            |-> (o_data.types_known == 5'(mtis_pkg::TYPE_SLOTS)))
        else $error("table full reported while slots remain");

    a_new_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == mtis_pkg::ST_ADDED)
            |-> (o_data.hit_count == 32'd1) && (o_data.mean_gap_ms == 16'd0))
        else $error("new entry result not fresh");

endmodule
